[rtl/three_wire_synth_register_writer_core_macros.svh]
// Assertion helpers shared by the writer RTL.
`ifndef THREE_WIRE_SYNTH_REGISTER_WRITER_CORE_MACROS_SVH
`define THREE_WIRE_SYNTH_REGISTER_WRITER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Property holds on every rising clock edge outside reset.
`define TWSRW_ASSERT(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("twsrw assertion failed");
// Consequent holds in the cycle after the antecedent.
`define TWSRW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("twsrw assertion failed");
`else
`define TWSRW_ASSERT(lbl, clk, rst_n, expr)
`define TWSRW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/twsrw_pkg.sv]
package twsrw_pkg;

    localparam int unsigned TickW = 16;
    localparam int unsigned WordW = 16;
    localparam int unsigned FrameW = 25;
    localparam int unsigned BitCntW = 5;

    localparam logic [BitCntW-1:0] FRAME_BITS = 5'd25;
    localparam logic [FrameW-1:0] FRAME1_WORD = 25'h0000008;
    localparam logic [4:0] FRAME2_HEAD = 5'h11;

    localparam logic [TickW-1:0] PHASE_RESET = 16'd300;
    localparam logic [TickW-1:0] GUARD_RESET = 16'd100;
    localparam logic [TickW-1:0] LATCH_RESET = 16'd2000;

    localparam logic [1:0] CFG_PHASE = 2'd0;
    localparam logic [1:0] CFG_GUARD = 2'd1;
    localparam logic [1:0] CFG_LATCH = 2'd2;

    typedef enum logic [19:0] {
        STEP_IDLE = 20'd1 << 0,
        STEP_1    = 20'd1 << 1,
        STEP_2    = 20'd1 << 2,
        STEP_3    = 20'd1 << 3,
        STEP_4    = 20'd1 << 4,
        STEP_5    = 20'd1 << 5,
        STEP_BITS = 20'd1 << 6,
        STEP_7    = 20'd1 << 7,
        STEP_8    = 20'd1 << 8,
        STEP_9    = 20'd1 << 9,
        STEP_10   = 20'd1 << 10,
        STEP_11   = 20'd1 << 11,
        STEP_12   = 20'd1 << 12,
        STEP_13   = 20'd1 << 13,
        STEP_14   = 20'd1 << 14,
        STEP_15   = 20'd1 << 15,
        STEP_16   = 20'd1 << 16,
        STEP_17   = 20'd1 << 17,
        STEP_18   = 20'd1 << 18,
        STEP_19   = 20'd1 << 19
    } step_t;

    typedef struct packed {
        logic [TickW-1:0] phase_ticks;
        logic [TickW-1:0] guard_ticks;
        logic [TickW-1:0] latch_ticks;
    } cfg_t;

    typedef struct packed {
        logic clock_pin;
        logic data_pin;
        logic enable_pin;
        logic busy_res;
        logic done_res;
        logic start_ignored;
    } res_t;

endpackage

[rtl/twsrw_seq.sv]
module twsrw_seq (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               accept,
    input  logic                               mode,
    input  logic [twsrw_pkg::WordW-1:0]        channel_word,
    input  twsrw_pkg::cfg_t                    cfg,
    output twsrw_pkg::res_t                    res_next
);
    import twsrw_pkg::*;

    `include "three_wire_synth_register_writer_core_macros.svh"

    step_t                step_reg, step_next;
    logic [TickW-1:0]     tick_reg, tick_next;
    logic [BitCntW-1:0]   bit_count_reg, bit_count_next;
    logic [1:0]           bit_phase_reg, bit_phase_next;
    logic                 frame_reg, frame_next;
    logic [FrameW-1:0]    shift_reg, shift_next;
    logic                 clock_reg, clock_next;
    logic                 data_reg, data_next;
    logic                 enable_reg, enable_next;
    logic [WordW-1:0]     word_reg, word_next;

    logic [TickW-1:0]     len_raw;
    logic [TickW-1:0]     len_eff;
    logic [TickW:0]       tick_inc;
    logic                 wait_end;
    logic [BitCntW-1:0]   bit_inc;
    logic                 done;
    logic                 ignored;

    always_comb begin
        unique case (step_reg) inside
            STEP_BITS:                 len_raw = cfg.phase_ticks;
            STEP_3, STEP_9, STEP_19:   len_raw = cfg.latch_ticks;
            default:                   len_raw = cfg.guard_ticks;
        endcase
        // a zero length still waits one tick
        len_eff  = (len_raw == '0) ? TickW'(1) : len_raw;
        tick_inc = {1'b0, tick_reg} + (TickW+1)'(1);
        wait_end = tick_inc >= {1'b0, len_eff};
        bit_inc  = bit_count_reg + BitCntW'(1);
    end

    always_comb begin
        step_next      = step_reg;
        tick_next      = tick_reg;
        bit_count_next = bit_count_reg;
        bit_phase_next = bit_phase_reg;
        frame_next     = frame_reg;
        shift_next     = shift_reg;
        clock_next     = clock_reg;
        data_next      = data_reg;
        enable_next    = enable_reg;
        word_next      = word_reg;
        done           = 1'b0;
        ignored        = 1'b0;

        if (accept) begin
            if (mode) begin
                if (step_reg == STEP_IDLE) begin
                    word_next      = channel_word;
                    tick_next      = '0;
                    bit_count_next = '0;
                    bit_phase_next = '0;
                    frame_next     = 1'b0;
                    step_next      = STEP_1;
                end else begin
                    ignored = 1'b1;
                end
            end else if (step_reg != STEP_IDLE) begin
                if (!wait_end) begin
                    tick_next = tick_inc[TickW-1:0];
                end else begin
                    tick_next = '0;
                    unique case (step_reg)
                        STEP_BITS: begin
                            case (bit_phase_reg)
                                2'd0: begin
                                    data_next      = shift_reg[0];
                                    bit_phase_next = 2'd1;
                                end
                                2'd1: begin
                                    clock_next     = 1'b1;
                                    bit_phase_next = 2'd2;
                                end
                                2'd2: begin
                                    clock_next     = 1'b0;
                                    bit_phase_next = 2'd3;
                                end
                                default: begin
                                    shift_next     = shift_reg >> 1;
                                    bit_phase_next = 2'd0;
                                    if (bit_inc >= FRAME_BITS) begin
                                        bit_count_next = '0;
                                        step_next      = frame_reg ? STEP_17 : STEP_7;
                                    end else begin
                                        bit_count_next = bit_inc;
                                    end
                                end
                            endcase
                        end
                        STEP_1: begin
                            enable_next = 1'b1;
                            step_next   = STEP_2;
                        end
                        STEP_2:  step_next = STEP_3;
                        STEP_3:  step_next = STEP_4;
                        STEP_4: begin
                            enable_next = 1'b0;
                            step_next   = STEP_5;
                        end
                        STEP_5: begin
                            clock_next     = 1'b0;
                            frame_next     = 1'b0;
                            shift_next     = FRAME1_WORD;
                            bit_count_next = '0;
                            bit_phase_next = '0;
                            step_next      = STEP_BITS;
                        end
                        STEP_7: begin
                            enable_next = 1'b1;
                            step_next   = STEP_8;
                        end
                        STEP_8:  step_next = STEP_9;
                        STEP_9:  step_next = STEP_10;
                        STEP_10: begin
                            enable_next = 1'b0;
                            step_next   = STEP_11;
                        end
                        STEP_11: step_next = STEP_12;
                        STEP_12: begin
                            enable_next = 1'b1;
                            step_next   = STEP_13;
                        end
                        STEP_13: step_next = STEP_14;
                        STEP_14: begin
                            enable_next = 1'b0;
                            step_next   = STEP_15;
                        end
                        STEP_15: begin
                            clock_next     = 1'b0;
                            frame_next     = 1'b1;
                            shift_next     = {4'b0000, word_reg, FRAME2_HEAD};
                            bit_count_next = '0;
                            bit_phase_next = '0;
                            step_next      = STEP_BITS;
                        end
                        STEP_16: step_next = STEP_17;
                        STEP_17: begin
                            enable_next = 1'b1;
                            step_next   = STEP_18;
                        end
                        STEP_18: step_next = STEP_19;
                        STEP_19: begin
                            // end of script: park the lines and go idle
                            enable_next = 1'b1;
                            clock_next  = 1'b0;
                            data_next   = 1'b0;
                            step_next   = STEP_IDLE;
                            done        = 1'b1;
                        end
                        default: step_next = STEP_IDLE;
                    endcase
                end
            end
        end

        res_next.clock_pin     = clock_next;
        res_next.data_pin      = data_next;
        res_next.enable_pin    = enable_next;
        res_next.busy_res      = (step_next != STEP_IDLE);
        res_next.done_res      = done;
        res_next.start_ignored = ignored;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= STEP_IDLE;
            tick_reg      <= '0;
            bit_count_reg <= '0;
            bit_phase_reg <= '0;
            frame_reg     <= 1'b0;
            shift_reg     <= '0;
            clock_reg     <= 1'b0;
            data_reg      <= 1'b0;
            enable_reg    <= 1'b1;
            word_reg      <= '0;
        end else begin
            step_reg      <= step_next;
            tick_reg      <= tick_next;
            bit_count_reg <= bit_count_next;
            bit_phase_reg <= bit_phase_next;
            frame_reg     <= frame_next;
            shift_reg     <= shift_next;
            clock_reg     <= clock_next;
            data_reg      <= data_next;
            enable_reg    <= enable_next;
            word_reg      <= word_next;
        end
    end

    `TWSRW_ASSERT(a_idle_lines_parked, aclk, aresetn,
        (step_reg != STEP_IDLE) || (enable_reg && !clock_reg && !data_reg))
    `TWSRW_ASSERT_NEXT(a_busy_start_no_effect, aclk, aresetn,
        accept && mode && (step_reg != STEP_IDLE),
        $stable(step_reg) && $stable(tick_reg) && $stable(word_reg))
    `TWSRW_ASSERT(a_bit_count_in_frame, aclk, aresetn, bit_count_reg < FRAME_BITS)

endmodule

[rtl/three_wire_synth_register_writer_core.sv]
// Three-wire synthesizer register writer. Each s_ transfer is a tick (mode 0)
// or a start (mode 1, loads s_channel_word); every transfer yields exactly one
// m_ result with the clock, data and enable line levels after that item, plus
// busy, done and start-ignored flags. One item per clock is sustained while
// m_ready is high: the sequencer updates its state, the result lands in the
// output register, and s_ready stays high while it is empty or being drained.
// Wait lengths come from phase_ticks, guard_ticks and latch_ticks, set at cfg_
// indexes 0, 1 and 2, which the user must write only while no s_ item is in
// flight (unenforced); a new value applies from the next tick, even mid-write.
module three_wire_synth_register_writer_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_mode,
    input  logic [twsrw_pkg::WordW-1:0]        s_channel_word,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_clock_pin,
    output logic                               m_data_pin,
    output logic                               m_enable_pin,
    output logic                               m_busy_res,
    output logic                               m_done_res,
    output logic                               m_start_ignored,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [1:0]                         cfg_index,
    input  logic [twsrw_pkg::TickW-1:0]        cfg_data
);
    import twsrw_pkg::*;

    `include "three_wire_synth_register_writer_core_macros.svh"

    cfg_t  cfg_reg;
    res_t  res_next;
    res_t  res_reg;
    logic  m_valid_reg;
    logic  s_accept;
    logic  cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign s_ready   = !m_valid_reg || m_ready;
    assign s_accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.phase_ticks <= PHASE_RESET;
            cfg_reg.guard_ticks <= GUARD_RESET;
            cfg_reg.latch_ticks <= LATCH_RESET;
        end else if (cfg_write) begin
            unique case (cfg_index)
                CFG_PHASE: cfg_reg.phase_ticks <= cfg_data;
                CFG_GUARD: cfg_reg.guard_ticks <= cfg_data;
                CFG_LATCH: cfg_reg.latch_ticks <= cfg_data;
                default: ;  // drop writes beyond the register list
            endcase
        end
    end

    twsrw_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (s_accept),
        .mode         (s_mode),
        .channel_word (s_channel_word),
        .cfg          (cfg_reg),
        .res_next     (res_next)
    );

    // hold the result until the transfer on the m_ side completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            res_reg <= res_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_clock_pin     = res_reg.clock_pin;
    assign m_data_pin      = res_reg.data_pin;
    assign m_enable_pin    = res_reg.enable_pin;
    assign m_busy_res      = res_reg.busy_res;
    assign m_done_res      = res_reg.done_res;
    assign m_start_ignored = res_reg.start_ignored;

    `TWSRW_ASSERT_NEXT(a_accept_fills_output, aclk, aresetn, s_accept, m_valid_reg)
    `TWSRW_ASSERT(a_done_means_parked, aclk, aresetn,
        !(m_valid_reg && res_reg.done_res) ||
        (!res_reg.busy_res && res_reg.enable_pin && !res_reg.clock_pin))
    `TWSRW_ASSERT_NEXT(a_phase_write_lands, aclk, aresetn,
        cfg_write && (cfg_index == CFG_PHASE),
        cfg_reg.phase_ticks == $past(cfg_data))

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    import twsrw_pkg::*;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_START = 1'b1;

    // Pin levels packed as {clock, data, enable, busy, done, ignored}
    localparam logic [5:0] PINS_IDLE     = 6'b001000;
    localparam logic [5:0] PINS_LOADED   = 6'b001100;
    localparam logic [5:0] PINS_REJECTED = 6'b001101;

    typedef struct {
        logic        mode;
        logic [15:0] word;
        bit          typed;
        logic [5:0]  pins;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic        s_mode;
    logic [15:0] s_channel_word;
    logic        m_valid;
    logic        m_ready;
    logic        m_clock_pin;
    logic        m_data_pin;
    logic        m_enable_pin;
    logic        m_busy_res;
    logic        m_done_res;
    logic        m_start_ignored;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // Writer state as the testbench sees it
    cfg_t        wr_cfg;
    step_t       wr_step;
    logic [15:0] wr_ticks;
    logic [4:0]  wr_bits;
    logic [1:0]  wr_phase;
    logic        wr_frame2;
    logic [24:0] wr_shift;
    logic        wr_clk;
    logic        wr_data;
    logic        wr_en;
    logic [15:0] wr_word;

    res_t        pin_expect_q[$];
    int          err_cnt = 0;
    int          n_items = 0;
    int          n_writes = 0;
    int          n_rejected = 0;
    int          n_settings = 0;
    int          burst_left = 0;
    int          rx_mode = 0;
    logic [31:0] rx_cycle = '0;

    stim_row_t dir_rows [0:8] = '{
        '{MODE_TICK,  16'h0000, 1'b1, PINS_IDLE},
        '{MODE_TICK,  16'hFFFF, 1'b1, PINS_IDLE},
        '{MODE_START, 16'hFFFF, 1'b1, PINS_LOADED},
        '{MODE_START, 16'h0000, 1'b1, PINS_REJECTED},
        '{MODE_START, 16'h5A5A, 1'b1, PINS_REJECTED},
        '{MODE_TICK,  16'h1234, 1'b0, PINS_IDLE},
        '{MODE_TICK,  16'hEDCB, 1'b0, PINS_IDLE},
        '{MODE_TICK,  16'h8001, 1'b0, PINS_IDLE},
        '{MODE_TICK,  16'h7FFE, 1'b0, PINS_IDLE}
    };

    three_wire_synth_register_writer_core u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_mode          (s_mode),
        .s_channel_word  (s_channel_word),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_clock_pin     (m_clock_pin),
        .m_data_pin      (m_data_pin),
        .m_enable_pin    (m_enable_pin),
        .m_busy_res      (m_busy_res),
        .m_done_res      (m_done_res),
        .m_start_ignored (m_start_ignored),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned wait_len();
        logic [15:0] len;
        if (wr_step == STEP_BITS) begin
            len = wr_cfg.phase_ticks;
        end else if (wr_step == STEP_3 || wr_step == STEP_9 || wr_step == STEP_19) begin
            len = wr_cfg.latch_ticks;
        end else begin
            len = wr_cfg.guard_ticks;
        end
        return (len == 16'd0) ? 1 : int'(len);
    endfunction

    // Close the current wait; returns 1 when the whole write has finished
    function automatic bit close_wait();
        case (wr_step)
            STEP_BITS: begin
                case (wr_phase)
                    2'd0: wr_data = wr_shift[0];
                    2'd1: wr_clk = 1'b1;
                    2'd2: wr_clk = 1'b0;
                    default: begin
                        wr_shift = wr_shift >> 1;
                        wr_bits = wr_bits + 5'd1;
                        if (wr_bits >= FRAME_BITS) begin
                            wr_bits = '0;
                            wr_phase = '0;
                            wr_step = wr_frame2 ? STEP_17 : STEP_7;
                            return 1'b0;
                        end
                    end
                endcase
                wr_phase = wr_phase + 2'd1;
                return 1'b0;
            end
            STEP_1, STEP_7, STEP_12, STEP_17: wr_en = 1'b1;
            STEP_4, STEP_10, STEP_14: wr_en = 1'b0;
            STEP_5: begin
                wr_clk = 1'b0;
                wr_frame2 = 1'b0;
                wr_shift = FRAME1_WORD;
                wr_bits = '0;
                wr_phase = '0;
                wr_step = STEP_BITS;
                return 1'b0;
            end
            STEP_15: begin
                wr_clk = 1'b0;
                wr_frame2 = 1'b1;
                wr_shift = {4'b0000, wr_word, FRAME2_HEAD};
                wr_bits = '0;
                wr_phase = '0;
                wr_step = STEP_BITS;
                return 1'b0;
            end
            STEP_19: begin
                wr_en = 1'b1;
                wr_clk = 1'b0;
                wr_data = 1'b0;
                wr_step = STEP_IDLE;
                return 1'b1;
            end
            default: ;
        endcase
        wr_step = step_t'(wr_step << 1);
        return 1'b0;
    endfunction

    function automatic res_t advance_writer(input logic mode, input logic [15:0] word);
        res_t r;
        bit   fin;
        bit   rej;
        fin = 1'b0;
        rej = 1'b0;
        if (mode == MODE_START) begin
            if (wr_step == STEP_IDLE) begin
                wr_word = word;
                wr_ticks = '0;
                wr_bits = '0;
                wr_phase = '0;
                wr_frame2 = 1'b0;
                wr_step = STEP_1;
            end else begin
                rej = 1'b1;
            end
        end else if (wr_step != STEP_IDLE) begin
            if (int'(wr_ticks) + 1 >= wait_len()) begin
                wr_ticks = '0;
                fin = close_wait();
            end else begin
                wr_ticks = wr_ticks + 16'd1;
            end
        end
        r.clock_pin = wr_clk;
        r.data_pin = wr_data;
        r.enable_pin = wr_en;
        r.busy_res = (wr_step != STEP_IDLE);
        r.done_res = fin;
        r.start_ignored = rej;
        return r;
    endfunction

    task automatic idle_sender(input int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    task automatic send_item(input logic mode, input logic [15:0] word, input bit typed,
                             input logic [5:0] pins, output bit fin);
        res_t want;
        if (burst_left == 0) begin
            // Now and then a long burst with no gaps at all
            if ($urandom_range(0, 7) == 0) begin
                burst_left = $urandom_range(64, 256);
            end else begin
                idle_sender($urandom_range(1, 6));
                burst_left = $urandom_range(1, 24);
            end
        end
        burst_left--;
        want = advance_writer(mode, word);
        if (typed) begin
            want = res_t'(pins);
        end
        pin_expect_q.push_back(want);
        fin = want.done_res;
        n_items++;
        n_writes += want.done_res;
        n_rejected += want.start_ignored;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_mode <= mode;
        s_channel_word <= word;
        do @(posedge aclk); while (!s_ready);
    endtask

    function automatic logic [15:0] pick_word();
        case ($urandom_range(0, 3))
            0: return 16'h0000;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // Mostly ticks; starts are common while idle and rare (rejected) while busy
    task automatic run_phase(input int target);
        int   finished;
        bit   fin;
        logic mode;
        finished = 0;
        while (finished < target) begin
            if (wr_step == STEP_IDLE) begin
                mode = ($urandom_range(0, 2) == 0) ? MODE_START : MODE_TICK;
            end else begin
                mode = ($urandom_range(0, 59) == 0) ? MODE_START : MODE_TICK;
            end
            send_item(mode, (mode == MODE_START) ? pick_word() : 16'($urandom_range(0, 16'hFFFF)),
                      1'b0, '0, fin);
            finished += fin;
        end
        repeat ($urandom_range(1, 3)) send_item(MODE_TICK, pick_word(), 1'b0, '0, fin);
    endtask

    task automatic settle();
        idle_sender(1);
        while (pin_expect_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [15:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_PHASE: wr_cfg.phase_ticks = data;
            CFG_GUARD: wr_cfg.guard_ticks = data;
            CFG_LATCH: wr_cfg.latch_ticks = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_setting(input logic [15:0] ph, input logic [15:0] gd,
                                 input logic [15:0] lt);
        settle();
        if ($urandom_range(0, 1) == 0) begin
            cfg_write(CFG_PHASE, ph);
            cfg_write(CFG_GUARD, gd);
            cfg_write(CFG_LATCH, lt);
        end else begin
            cfg_write(CFG_LATCH, lt);
            cfg_write(CFG_GUARD, gd);
            cfg_write(CFG_PHASE, ph);
        end
        n_settings++;
    endtask

    task automatic check_pin(input string name, input logic want, input logic got);
        if (got !== want) begin
            err_cnt++;
            // Keep the log bounded if the block is badly broken
            if (err_cnt <= 100) begin
                $display("%0t: %s mismatch, expected %b, actual %b", $time, name, want, got);
            end
        end
    endtask

    // Receiver: m_ready follows a stall pattern that is redrawn at random
    always @(negedge aclk) begin
        rx_cycle <= rx_cycle + 32'd1;
        if (rx_cycle % 100 == 0) begin
            rx_mode <= $urandom_range(0, 3);
        end
        case (rx_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            2: m_ready <= rx_cycle[0];
            default: m_ready <= (rx_cycle[1:0] == 2'd0);
        endcase
    end

    always @(posedge aclk) begin : result_check
        res_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pin_expect_q.size() == 0) begin
                err_cnt++;
                $display("%0t: unexpected transfer, expected none, actual %b", $time,
                         {m_clock_pin, m_data_pin, m_enable_pin, m_busy_res, m_done_res,
                          m_start_ignored});
            end else begin
                want = pin_expect_q.pop_front();
                check_pin("clock_pin", want.clock_pin, m_clock_pin);
                check_pin("data_pin", want.data_pin, m_data_pin);
                check_pin("enable_pin", want.enable_pin, m_enable_pin);
                check_pin("busy_res", want.busy_res, m_busy_res);
                check_pin("done_res", want.done_res, m_done_res);
                check_pin("start_ignored", want.start_ignored, m_start_ignored);
            end
        end
    end

    initial begin
        #40_000_000;
        $display("Timeout with %0d results outstanding", pin_expect_q.size());
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        bit fin;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_mode = MODE_TICK;
        s_channel_word = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PHASE;
        cfg_data = '0;

        wr_cfg.phase_ticks = PHASE_RESET;
        wr_cfg.guard_ticks = GUARD_RESET;
        wr_cfg.latch_ticks = LATCH_RESET;
        wr_step = STEP_IDLE;
        wr_ticks = '0;
        wr_bits = '0;
        wr_phase = '0;
        wr_frame2 = 1'b0;
        wr_shift = '0;
        wr_clk = 1'b0;
        wr_data = 1'b0;
        wr_en = 1'b1;
        wr_word = '0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // Reset timing first: walk the table, then tick into the first guard wait
        foreach (dir_rows[i]) begin
            send_item(dir_rows[i].mode, dir_rows[i].word, dir_rows[i].typed,
                      dir_rows[i].pins, fin);
        end
        repeat (30) send_item(MODE_TICK, pick_word(), 1'b0, '0, fin);

        // Shorter waits land mid-write and apply from the next tick
        apply_setting(16'd2, 16'd2, 16'd3);
        run_phase(1);
        // Zero behaves as a single tick
        apply_setting(16'd0, 16'd0, 16'd0);
        run_phase(1);

        // Longest waits: the write cannot finish within the run, so leave it busy
        apply_setting(16'hFFFF, 16'hFFFF, 16'hFFFF);
        repeat (3) send_item(MODE_TICK, pick_word(), 1'b0, '0, fin);
        send_item(MODE_START, pick_word(), 1'b0, '0, fin);
        repeat (40) begin
            send_item(($urandom_range(0, 29) == 0) ? MODE_START : MODE_TICK, pick_word(),
                      1'b0, '0, fin);
        end

        idle_sender(1);
        while (pin_expect_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d items over %0d register settings plus reset values", n_items,
                 n_settings);
        $display("Completed %0d channel writes, %0d starts rejected while busy", n_writes,
                 n_rejected);
        if (err_cnt == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/twsrw_pkg.sv
rtl/twsrw_seq.sv
rtl/three_wire_synth_register_writer_core.sv
verif/tb_top.sv
